// ===== hw/rtl/sslf_pkg.sv =====
`timescale 1ns / 1ps

package sslf_pkg;

  localparam int unsigned IdxW  = 3;
  localparam int unsigned MacW  = 8;
  localparam int unsigned TickW = 32;
  localparam int unsigned StW   = 3;
  localparam int unsigned MaxSlots = 8;

  localparam logic [2:0] OP_BIND   = 3'd0;
  localparam logic [2:0] OP_START  = 3'd1;
  localparam logic [2:0] OP_PAIR   = 3'd2;
  localparam logic [2:0] OP_REPORT = 3'd3;
  localparam logic [2:0] OP_ACK    = 3'd4;
  localparam logic [2:0] OP_TICK   = 3'd5;

  localparam logic [StW-1:0] ST_EMPTY   = 3'd0;
  localparam logic [StW-1:0] ST_PAIRING = 3'd1;
  localparam logic [StW-1:0] ST_OK      = 3'd2;
  localparam logic [StW-1:0] ST_ALARM   = 3'd3;
  localparam logic [StW-1:0] ST_OFFLINE = 3'd4;

  localparam logic CFG_PAIRING_TO = 1'b0;
  localparam logic CFG_OFFLINE_TO = 1'b1;

  localparam logic [TickW-1:0] PAIRING_TO_RST = 32'd30000;
  localparam logic [TickW-1:0] OFFLINE_TO_RST = 32'd60000;

  typedef struct packed {
    logic [2:0]       opcode;
    logic [IdxW-1:0]  slot_sel;
    logic [MacW-1:0]  mac_address;
    logic             alarm_flag;
    logic [TickW-1:0] now_ticks;
  } sslf_in_t;

  typedef struct packed {
    logic                      op_result;
    logic [StW*MaxSlots-1:0]   slot_states;
    logic [MaxSlots-1:0]       offline_unacked_mask;
  } sslf_out_t;

  // Command token that walks the row of slot cells.
  typedef struct packed {
    logic             valid;
    logic             in_range;
    logic             claimed;
    logic             result;
    logic [2:0]       opcode;
    logic [IdxW-1:0]  slot_sel;
    logic [MacW-1:0]  mac_address;
    logic             alarm_flag;
    logic [TickW-1:0] now_ticks;
  } sslf_tok_t;

endpackage

// ===== hw/rtl/sslf_cell.sv =====
`timescale 1ns / 1ps

module sslf_cell #(
  parameter int CELL_IDX = 0
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [sslf_pkg::TickW-1:0]    pairing_to,
  input  logic [sslf_pkg::TickW-1:0]    offline_to,
  input  sslf_pkg::sslf_tok_t           tok_in,
  output sslf_pkg::sslf_tok_t           tok_out,
  output logic [sslf_pkg::StW-1:0]      state,
  output logic                          offline_unacked
);
  import sslf_pkg::*;

  logic [StW-1:0]   state_r, state_nxt;
  logic [MacW-1:0]  addr_r, addr_nxt;
  logic [TickW-1:0] start_r, start_nxt;
  logic [TickW-1:0] seen_r, seen_nxt;
  logic             ack_r, ack_nxt;
  logic             run_r, run_nxt;
  logic             seen_ok_r, seen_ok_nxt;
  sslf_tok_t        tok_r, tok_nxt;
  logic             sel;
  logic [TickW-1:0] pair_age;
  logic [TickW-1:0] seen_age;

  assign sel      = tok_in.in_range && (tok_in.slot_sel == IdxW'(CELL_IDX));
  assign pair_age = tok_in.now_ticks - start_r;
  assign seen_age = tok_in.now_ticks - seen_r;

  always_comb begin
    state_nxt   = state_r;
    addr_nxt    = addr_r;
    start_nxt   = start_r;
    seen_nxt    = seen_r;
    ack_nxt     = ack_r;
    run_nxt     = run_r;
    seen_ok_nxt = seen_ok_r;
    tok_nxt     = tok_in;
    if (tok_in.valid) begin
      unique case (tok_in.opcode)
        OP_BIND: begin
          if (sel) begin
            addr_nxt    = tok_in.mac_address;
            start_nxt   = '0;
            seen_nxt    = '0;
            run_nxt     = 1'b0;
            seen_ok_nxt = 1'b0;
            ack_nxt     = 1'b0;
            state_nxt   = (tok_in.mac_address != '0) ? ST_OK : ST_EMPTY;
          end
        end
        OP_START: begin
          if (tok_in.in_range) begin
            if (state_r == ST_PAIRING) begin
              addr_nxt  = '0;
              start_nxt = '0;
              run_nxt   = 1'b0;
              ack_nxt   = 1'b0;
              state_nxt = ST_EMPTY;
            end else if (sel && (state_r == ST_EMPTY || state_r == ST_OK)) begin
              state_nxt      = ST_PAIRING;
              start_nxt      = tok_in.now_ticks;
              run_nxt        = 1'b1;
              tok_nxt.result = 1'b1;
            end
          end
        end
        OP_PAIR: begin
          if (!tok_in.claimed && state_r == ST_PAIRING) begin
            addr_nxt        = tok_in.mac_address;
            state_nxt       = ST_OK;
            seen_nxt        = tok_in.now_ticks;
            seen_ok_nxt     = 1'b1;
            tok_nxt.claimed = 1'b1;
            tok_nxt.result  = 1'b1;
          end
        end
        OP_REPORT: begin
          if (!tok_in.claimed && state_r != ST_EMPTY &&
              addr_r == tok_in.mac_address) begin
            seen_nxt        = tok_in.now_ticks;
            seen_ok_nxt     = 1'b1;
            tok_nxt.claimed = 1'b1;
            if (tok_in.alarm_flag) begin
              if (state_r == ST_OK) begin
                state_nxt = ST_ALARM;
              end
            end else if (state_r == ST_PAIRING || state_r == ST_ALARM) begin
              state_nxt = ST_OK;
            end else if (state_r == ST_OFFLINE) begin
              state_nxt = ST_OK;
              ack_nxt   = 1'b0;
            end
          end
        end
        OP_ACK: begin
          if (sel && state_r == ST_OFFLINE && !ack_r) begin
            ack_nxt        = 1'b1;
            tok_nxt.result = 1'b1;
          end
        end
        OP_TICK: begin
          if (state_r == ST_PAIRING && run_r && pair_age > pairing_to) begin
            addr_nxt       = '0;
            start_nxt      = '0;
            run_nxt        = 1'b0;
            ack_nxt        = 1'b0;
            state_nxt      = ST_EMPTY;
            tok_nxt.result = 1'b1;
          end else if ((state_r == ST_OK || state_r == ST_ALARM) && seen_ok_r &&
                       seen_age > offline_to) begin
            state_nxt = ST_OFFLINE;
            ack_nxt   = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_EMPTY;
      addr_r    <= '0;
      start_r   <= '0;
      seen_r    <= '0;
      ack_r     <= 1'b0;
      run_r     <= 1'b0;
      seen_ok_r <= 1'b0;
      tok_r     <= '0;
    end else begin
      state_r   <= state_nxt;
      addr_r    <= addr_nxt;
      start_r   <= start_nxt;
      seen_r    <= seen_nxt;
      ack_r     <= ack_nxt;
      run_r     <= run_nxt;
      seen_ok_r <= seen_ok_nxt;
      tok_r     <= tok_nxt;
    end
  end

  assign tok_out         = tok_r;
  assign state           = state_r;
  assign offline_unacked = (state_r == ST_OFFLINE) && !ack_r;

endmodule

// ===== hw/rtl/sensor_slot_liveness_fsm_top.sv =====
`timescale 1ns / 1ps

// Sensor slot table with per-slot liveness tracking.
// Commands are presented on in_data and transferred at a rising edge where
// start is high and busy is low. Configuration registers (pairing and offline
// timeouts) are written through cfg_we, cfg_index and cfg_wdata at any edge
// where cfg_we is high, and should only change while busy is low.
// Each slot lives in its own cell; the command travels down the row of cells,
// one cell per cycle, so every slot sees it in turn and lower slots win the
// search for pair and report commands.
// One result transfer follows every command: out_valid rises once the command
// has passed the command register and every slot cell, and is high for exactly
// one cycle. out_data then holds the operation result together with all slot
// states and the unacknowledged offline mask. busy stays high from the command
// transfer through the result cycle, so a new command is taken only after the
// result of the previous one has been delivered.
// The receiver cannot stall; it must take each result in its strobe cycle.
// Reset empties all slots and loads the default timeouts.
module sensor_slot_liveness_fsm_top #(
  parameter int NUM_SLOTS = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  sslf_pkg::sslf_in_t            in_data,
  output logic                          out_valid,
  output sslf_pkg::sslf_out_t           out_data,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [sslf_pkg::TickW-1:0]    cfg_wdata
);
  import sslf_pkg::*;

  logic [TickW-1:0] pairing_to_r;
  logic [TickW-1:0] offline_to_r;
  logic             busy_r, busy_nxt;
  sslf_tok_t        tok0_r, tok0_nxt;
  sslf_tok_t        tok [NUM_SLOTS+1];
  logic [StW-1:0]   cell_state [NUM_SLOTS];
  logic             cell_unacked [NUM_SLOTS];
  logic             accept;

  assign accept = start && !busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pairing_to_r <= PAIRING_TO_RST;
      offline_to_r <= OFFLINE_TO_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PAIRING_TO: pairing_to_r <= cfg_wdata;
        CFG_OFFLINE_TO: offline_to_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    tok0_nxt = '0;
    if (accept) begin
      busy_nxt            = 1'b1;
      tok0_nxt.valid      = 1'b1;
      tok0_nxt.in_range   = (32'(in_data.slot_sel) < NUM_SLOTS);
      tok0_nxt.opcode     = in_data.opcode;
      tok0_nxt.slot_sel   = in_data.slot_sel;
      tok0_nxt.mac_address = in_data.mac_address;
      tok0_nxt.alarm_flag = in_data.alarm_flag;
      tok0_nxt.now_ticks  = in_data.now_ticks;
    end else if (tok[NUM_SLOTS].valid) begin
      busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      tok0_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      tok0_r <= tok0_nxt;
    end
  end

  assign tok[0] = tok0_r;

  for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_cell
    sslf_cell #(
      .CELL_IDX(g)
    ) u_cell (
      .clk             (clk),
      .rst_n           (rst_n),
      .pairing_to      (pairing_to_r),
      .offline_to      (offline_to_r),
      .tok_in          (tok[g]),
      .tok_out         (tok[g+1]),
      .state           (cell_state[g]),
      .offline_unacked (cell_unacked[g])
    );
  end

  for (genvar g = 0; g < MaxSlots; g++) begin : g_out
    if (g < NUM_SLOTS) begin : g_live
      assign out_data.slot_states[g*StW +: StW]   = cell_state[g];
      assign out_data.offline_unacked_mask[g]     = cell_unacked[g];
    end else begin : g_none
      assign out_data.slot_states[g*StW +: StW]   = '0;
      assign out_data.offline_unacked_mask[g]     = 1'b0;
    end
  end

  assign out_data.op_result = tok[NUM_SLOTS].result;
  assign out_valid          = tok[NUM_SLOTS].valid;
  assign busy               = busy_r;

endmodule

// ===== hw/rtl/sslf_chk.sv =====
`timescale 1ns / 1ps

module sslf_chk (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid
);

  // A command transfer makes the block busy.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("busy not raised after a command transfer");

  // A result only appears while a command is in flight.
  a_out_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result strobe without a command in flight");

  // Each result is a single-cycle strobe.
  a_out_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  // The block frees up right after delivering the result.
  a_free_after_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !busy)
    else $error("busy still high after the result transfer");

  // Busy only drops with a result.
  a_busy_until_out: assert property (@(posedge clk) disable iff (!rst_n)
    busy && !out_valid |=> busy)
    else $error("busy dropped without a result transfer");

endmodule

bind sensor_slot_liveness_fsm_top sslf_chk u_sslf_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid)
);
